### hw/rtl/queue_range_allocator_core_macros.svh
// ----------------------------------------------------------------------------
// Queue range allocator assertion macros
// Shorthand for the concurrent checks used by the allocator core.
// ----------------------------------------------------------------------------
`ifndef QUEUE_RANGE_ALLOCATOR_CORE_MACROS_SVH
`define QUEUE_RANGE_ALLOCATOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QRA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("queue range allocator: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define QRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("queue range allocator: next-cycle check failed");

`endif

### hw/rtl/qra_pkg.sv
// ----------------------------------------------------------------------------
// Queue range allocator package
// Shared constants, codes and word types of the queue range allocator.
// ----------------------------------------------------------------------------
package qra_pkg;

  // Number of queues in each direction's map.
  localparam int NUM_QUEUES = 256;

  // The maps are stored as rows of ROW_W queues.
  localparam int ROW_W     = 8;
  localparam int ROW_SH    = 3;
  localparam int NUM_ROWS  = (NUM_QUEUES + ROW_W - 1) / ROW_W;
  localparam int ROW_AW    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int RAM_DEPTH = 2 * (2 ** ROW_AW);
  // Map memory address: direction bit above the row number.
  localparam int RAM_AW    = ROW_AW + 1;

  // Width that holds a queue count up to NUM_QUEUES.
  localparam int QCW   = $clog2(NUM_QUEUES + 1);
  // Width of a queue position while walking rows (may pass the table end).
  localparam int POS_W = QCW + 1;
  // Width of base + count.
  localparam int SUM_W = (QCW > 10) ? QCW : 10;

  // Command queue between front and back.
  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW    = (CQ_DEPTH > 2) ? $clog2(CQ_DEPTH) : 1;
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

  // Register byte addresses.
  localparam logic [1:0] ADDR_SEARCH_LIMIT = 2'd0;
  localparam logic [8:0] SEARCH_LIMIT_RST  = 9'd256;

  typedef enum logic [2:0] {
    MODE_ASSIGN  = 3'd0,
    MODE_RELEASE = 3'd1,
    MODE_CHECK   = 3'd2,
    MODE_FIND    = 3'd3,
    MODE_CLEAR   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FALSE = 2'd1,
    ST_PAST  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    OP_REPORT = 3'd0,
    OP_MARK   = 3'd1,
    OP_CHECK  = 3'd2,
    OP_FIND   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_WALK = 1'b1
  } state_e;

  typedef struct packed {
    logic [2:0] mode;
    logic       queue_dir;
    logic [7:0] base;
    logic [8:0] count;
  } qra_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] found_base;
  } qra_out_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    op_e               op;
    logic              dir;
    logic              set_bit;
    logic [QCW-1:0]    lo;
    logic [QCW-1:0]    hi;
    logic [QCW-1:0]    count;
    logic [QCW-1:0]    limit;
    logic [ROW_AW-1:0] first_row;
    logic [ROW_AW-1:0] last_row;
    status_e           status;
  } qra_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qra_fifo_stat_t;

endpackage

### hw/rtl/qra_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module qra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/qra_front.sv
// ----------------------------------------------------------------------------
// Queue range allocator front end
// Accepts request words, screens out trivial and invalid ranges, and turns
// the rest into row-walk commands for the back end.
// ----------------------------------------------------------------------------
module qra_front (
  input  logic                    start,
  input  qra_pkg::qra_in_t        in_word,
  input  logic [8:0]              search_limit,
  input  qra_pkg::qra_fifo_stat_t fifo_stat,
  output logic                    busy,
  output logic                    push,
  output qra_pkg::qra_cmd_t       cmd
);

  logic [qra_pkg::SUM_W-1:0] sum;
  logic                      past;
  logic                      count_zero;
  logic                      too_big;
  logic [qra_pkg::QCW-1:0]   lim;
  logic [qra_pkg::QCW-1:0]   hi_m1;
  logic [qra_pkg::QCW-1:0]   lim_m1;

  assign busy = fifo_stat.full;
  assign push = start && !fifo_stat.full;

  always_comb begin
    sum  = qra_pkg::SUM_W'(in_word.base) + qra_pkg::SUM_W'(in_word.count);
    past = sum > qra_pkg::SUM_W'(qra_pkg::NUM_QUEUES);
    // A limit above the table size means the whole table.
    lim  = (qra_pkg::SUM_W'(search_limit) > qra_pkg::SUM_W'(qra_pkg::NUM_QUEUES)) ?
           qra_pkg::QCW'(qra_pkg::NUM_QUEUES) : qra_pkg::QCW'(search_limit);
    count_zero = (in_word.count == 9'd0);
    too_big    = qra_pkg::SUM_W'(in_word.count) > qra_pkg::SUM_W'(lim);
    hi_m1      = qra_pkg::QCW'(sum) - 1'b1;
    lim_m1     = lim - 1'b1;

    cmd.op        = qra_pkg::OP_REPORT;
    cmd.dir       = in_word.queue_dir;
    cmd.set_bit   = (in_word.mode == qra_pkg::MODE_ASSIGN);
    cmd.lo        = qra_pkg::QCW'(in_word.base);
    cmd.hi        = qra_pkg::QCW'(sum);
    cmd.count     = qra_pkg::QCW'(in_word.count);
    cmd.limit     = lim;
    cmd.first_row = qra_pkg::ROW_AW'(cmd.lo >> qra_pkg::ROW_SH);
    cmd.last_row  = qra_pkg::ROW_AW'(hi_m1 >> qra_pkg::ROW_SH);
    cmd.status    = qra_pkg::ST_OK;

    unique case (in_word.mode)
      qra_pkg::MODE_ASSIGN, qra_pkg::MODE_RELEASE: begin
        if (past) begin
          cmd.status = qra_pkg::ST_PAST;
        end else if (!count_zero) begin
          cmd.op = qra_pkg::OP_MARK;
        end
      end
      qra_pkg::MODE_CHECK: begin
        if (past) begin
          cmd.status = qra_pkg::ST_PAST;
        end else if (!count_zero) begin
          cmd.op = qra_pkg::OP_CHECK;
        end
      end
      qra_pkg::MODE_FIND: begin
        // An empty find succeeds at queue zero whatever the limit.
        if (!count_zero) begin
          if (too_big) begin
            cmd.status = qra_pkg::ST_FALSE;
          end else begin
            cmd.op        = qra_pkg::OP_FIND;
            cmd.first_row = '0;
            cmd.last_row  = qra_pkg::ROW_AW'(lim_m1 >> qra_pkg::ROW_SH);
          end
        end
      end
      qra_pkg::MODE_CLEAR: begin
        cmd.op = qra_pkg::OP_CLEAR;
      end
      default: begin
        cmd.status = qra_pkg::ST_FALSE;
      end
    endcase
  end

endmodule

### hw/rtl/qra_fifo.sv
// ----------------------------------------------------------------------------
// Queue range allocator command queue
// Short queue of classified commands between the front and back ends.
// ----------------------------------------------------------------------------
module qra_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  qra_pkg::qra_cmd_t       cmd_in,
  input  logic                    pop,
  output qra_pkg::qra_cmd_t       cmd_out,
  output qra_pkg::qra_fifo_stat_t fifo_stat
);

  qra_pkg::qra_cmd_t           mem_r [qra_pkg::CQ_DEPTH];
  logic [qra_pkg::CQ_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [qra_pkg::CQ_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [qra_pkg::CQ_CW-1:0]   cnt_r, cnt_nxt;
  logic                        do_push;
  logic                        do_pop;

  assign fifo_stat.full  = (cnt_r == qra_pkg::CQ_CW'(qra_pkg::CQ_DEPTH));
  assign fifo_stat.empty = (cnt_r == '0);
  assign do_push         = push && !fifo_stat.full;
  assign do_pop          = pop && !fifo_stat.empty;
  assign cmd_out         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == qra_pkg::CQ_AW'(qra_pkg::CQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == qra_pkg::CQ_AW'(qra_pkg::CQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + qra_pkg::CQ_CW'(do_push) - qra_pkg::CQ_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

### hw/rtl/qra_back.sv
// ----------------------------------------------------------------------------
// Queue range allocator back end
// Walks the in-use map one row per cycle to mark, check or search a range,
// and drives the result word.
// ----------------------------------------------------------------------------
module qra_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  qra_pkg::qra_fifo_stat_t fifo_stat,
  input  qra_pkg::qra_cmd_t       cmd_in,
  output logic                    pop,
  output logic                    out_valid,
  output qra_pkg::qra_out_t       out_word
);

  qra_pkg::state_e               state_r, state_nxt;
  qra_pkg::qra_cmd_t             cmd_r, cmd_nxt;
  logic [qra_pkg::ROW_AW-1:0]    row_r, row_nxt;
  logic                          all_r, all_nxt;
  logic [qra_pkg::QCW-1:0]       run_r, run_nxt;
  logic                          rd_vld_r;
  logic [qra_pkg::RAM_DEPTH-1:0] vld_r, vld_nxt;
  logic                          out_valid_r, out_valid_nxt;
  qra_pkg::qra_out_t             out_word_r, out_word_nxt;

  logic                          rd_en;
  logic [qra_pkg::RAM_AW-1:0]    rd_addr;
  logic                          wr_en;
  logic [qra_pkg::RAM_AW-1:0]    wr_addr;
  logic [qra_pkg::ROW_W-1:0]     wr_data;
  logic [qra_pkg::ROW_W-1:0]     rd_data;
  logic [qra_pkg::ROW_W-1:0]     row_bits;
  logic [qra_pkg::ROW_W-1:0]     mask;
  logic                          row_last;
  logic                          all_row;
  logic                          hit;
  logic [qra_pkg::POS_W-1:0]     hit_base;
  logic [qra_pkg::QCW-1:0]       run_end;

  qra_ram #(
    .WIDTH (qra_pkg::ROW_W),
    .DEPTH (qra_pkg::RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign row_last = (row_r == cmd_r.last_row);

  // Evaluate the row that just came back from the map.
  always_comb begin : row_eval
    logic [qra_pkg::POS_W-1:0] q0;
    logic [qra_pkg::POS_W-1:0] qj;
    logic [qra_pkg::QCW-1:0]   run;
    q0       = qra_pkg::POS_W'({row_r, {qra_pkg::ROW_SH{1'b0}}});
    row_bits = rd_vld_r ? rd_data : '0;
    run      = run_r;
    hit      = 1'b0;
    hit_base = '0;
    for (int j = 0; j < qra_pkg::ROW_W; j++) begin
      qj      = q0 + qra_pkg::POS_W'(j);
      mask[j] = (qj >= qra_pkg::POS_W'(cmd_r.lo)) && (qj < qra_pkg::POS_W'(cmd_r.hi));
      if (!hit) begin
        // Queues at or above the limit count as taken.
        if (row_bits[j] || (qj >= qra_pkg::POS_W'(cmd_r.limit))) begin
          run = '0;
        end else begin
          run = run + 1'b1;
        end
        if (run == cmd_r.count) begin
          hit      = 1'b1;
          hit_base = qj + 1'b1 - qra_pkg::POS_W'(cmd_r.count);
        end
      end
    end
    run_end = run;
    all_row = ((~row_bits & mask) == '0);
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    row_nxt       = row_r;
    all_nxt       = all_r;
    run_nxt       = run_r;
    vld_nxt       = vld_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    pop           = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = {cmd_r.dir, row_r};
    wr_en         = 1'b0;
    wr_addr       = {cmd_r.dir, row_r};
    wr_data       = cmd_r.set_bit ? (row_bits | mask) : (row_bits & ~mask);

    unique case (state_r)
      qra_pkg::S_IDLE: begin
        if (!fifo_stat.empty) begin
          pop     = 1'b1;
          cmd_nxt = cmd_in;
          unique case (cmd_in.op)
            qra_pkg::OP_MARK, qra_pkg::OP_CHECK, qra_pkg::OP_FIND: begin
              rd_en     = 1'b1;
              rd_addr   = {cmd_in.dir, cmd_in.first_row};
              row_nxt   = cmd_in.first_row;
              run_nxt   = '0;
              all_nxt   = 1'b1;
              state_nxt = qra_pkg::S_WALK;
            end
            qra_pkg::OP_CLEAR: begin
              vld_nxt                 = '0;
              out_valid_nxt           = 1'b1;
              out_word_nxt.status     = qra_pkg::ST_OK;
              out_word_nxt.found_base = '0;
            end
            default: begin
              out_valid_nxt           = 1'b1;
              out_word_nxt.status     = cmd_in.status;
              out_word_nxt.found_base = '0;
            end
          endcase
        end
      end
      qra_pkg::S_WALK: begin
        if (cmd_r.op == qra_pkg::OP_MARK) begin
          wr_en            = 1'b1;
          vld_nxt[wr_addr] = 1'b1;
        end
        all_nxt = all_r && all_row;
        run_nxt = run_end;
        if (row_last || ((cmd_r.op == qra_pkg::OP_FIND) && hit)) begin
          state_nxt               = qra_pkg::S_IDLE;
          out_valid_nxt           = 1'b1;
          out_word_nxt.found_base = '0;
          unique case (cmd_r.op)
            qra_pkg::OP_MARK: begin
              out_word_nxt.status = qra_pkg::ST_OK;
            end
            qra_pkg::OP_CHECK: begin
              out_word_nxt.status = (all_r && all_row) ? qra_pkg::ST_OK : qra_pkg::ST_FALSE;
            end
            qra_pkg::OP_FIND: begin
              if (hit) begin
                out_word_nxt.status     = qra_pkg::ST_OK;
                out_word_nxt.found_base = 8'(hit_base);
              end else begin
                out_word_nxt.status = qra_pkg::ST_FALSE;
              end
            end
            default: begin
              out_word_nxt.status = qra_pkg::ST_FALSE;
            end
          endcase
        end else begin
          // Fetch the next row while a mark writes this one back.
          rd_en   = 1'b1;
          rd_addr = {cmd_r.dir, row_r + 1'b1};
          row_nxt = row_r + 1'b1;
        end
      end
      default: begin
        state_nxt = qra_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qra_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      vld_r       <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    row_r      <= row_nxt;
    all_r      <= all_nxt;
    run_r      <= run_nxt;
    out_word_r <= out_word_nxt;
    if (rd_en) begin
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

### hw/rtl/queue_range_allocator_core.sv
// ----------------------------------------------------------------------------
// Queue range allocator core
// First-fit contiguous range allocator over a transmit and a receive queue
// in-use map. A request word is taken when start is high and busy is low.
// Every request produces exactly one result word, shown on out_word for a
// single cycle with out_valid high; the receiver cannot stall it, so it must
// capture the word in that cycle. Results come back in request order. Clear,
// out-of-range, empty, oversized-find and unused-mode requests are answered
// without a map walk once the back end takes them from the queue. Assign,
// release and check walk the map one row of eight queues per cycle over the
// rows the range touches, and find walks from queue zero up to the row holding
// the last queue below the search limit, stopping at the first fit. That row
// walk through the single map memory sets the rate. Up to two further
// requests queue up behind the one being worked on; busy rises while that
// queue is full.
// search_limit may only be written while no request is in flight.
// ----------------------------------------------------------------------------
`include "queue_range_allocator_core_macros.svh"

module queue_range_allocator_core (
  input  logic              clk,
  input  logic              rst_n,
  // Request channel.
  input  logic              start,
  output logic              busy,
  input  qra_pkg::qra_in_t  in_word,
  // Result channel.
  output logic              out_valid,
  output qra_pkg::qra_out_t out_word,
  // Register port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // The only register, the search limit, lives at byte address zero.
  logic [8:0]              search_limit_r, search_limit_nxt;
  logic                    reg_wr;

  logic                    push;
  logic                    pop;
  qra_pkg::qra_cmd_t       front_cmd;
  qra_pkg::qra_cmd_t       queue_cmd;
  qra_pkg::qra_fifo_stat_t fifo_stat;

  // Requests taken but not yet answered; used by the checks below.
  logic [2:0]              pend_r, pend_nxt;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_comb begin
    search_limit_nxt = search_limit_r;
    if (reg_wr && (paddr == qra_pkg::ADDR_SEARCH_LIMIT)) begin
      search_limit_nxt = pwdata[8:0];
    end
    prdata = (paddr == qra_pkg::ADDR_SEARCH_LIMIT) ? {23'd0, search_limit_r} : 32'd0;
  end

  // The front end screens requests; the back end walks the maps.
  qra_front u_front (
    .start        (start),
    .in_word      (in_word),
    .search_limit (search_limit_r),
    .fifo_stat    (fifo_stat),
    .busy         (busy),
    .push         (push),
    .cmd          (front_cmd)
  );

  qra_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .cmd_in    (front_cmd),
    .pop       (pop),
    .cmd_out   (queue_cmd),
    .fifo_stat (fifo_stat)
  );

  qra_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fifo_stat (fifo_stat),
    .cmd_in    (queue_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  always_comb begin
    pend_nxt = pend_r + 3'(push) - 3'(out_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_limit_r <= qra_pkg::SEARCH_LIMIT_RST;
      pend_r         <= '0;
    end else begin
      search_limit_r <= search_limit_nxt;
      pend_r         <= pend_nxt;
    end
  end

  // A taken request is in the command queue on the next cycle.
  `QRA_ASSERT_NEXT(a_push_lands, start && !busy, !fifo_stat.empty)
  // A result word always answers an outstanding request.
  `QRA_ASSERT_NOW(a_no_orphan_result, out_valid, pend_r != 3'd0)
  // Only a successful find carries a nonzero base.
  `QRA_ASSERT_NOW(a_base_zero_on_fail, out_valid && (out_word.status != qra_pkg::ST_OK),
                  out_word.found_base == 8'd0)

endmodule
